// ===== hw/rtl/necdec_pkg.sv =====
// Shared types, constants and register indexes of the NEC IR frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package necdec_pkg;

  // Field widths of the channels and the configuration port.
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned CODE_W     = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Frame lengths in intervals, header mark included.
  localparam int unsigned FULL_FRAME_EDGES_DEF = 67;
  localparam int unsigned REPEAT_FRAME_EDGES   = 3;

  // Code and mask constants.
  localparam logic [CODE_W-1:0] FIRST_BIT_MASK = 32'h8000_0000;
  localparam logic [CODE_W-1:0] REPEAT_CODE    = 32'hFFFF_FFFF;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_FULL   = 2'd0,
    ST_REPEAT = 2'd1,
    ST_FAIL   = 2'd2
  } frame_status_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_WIN      = 3'd0,
    CFG_REPEAT_SPACE_WIN = 3'd1,
    CFG_FULL_SPACE_WIN  = 3'd2,
    CFG_BURST_WIN       = 3'd3,
    CFG_SHORT_SPACE_WIN = 3'd4,
    CFG_LONG_SPACE_WIN  = 3'd5
  } cfg_index_t;

  // Reset values of the timing windows (max in upper half, min in lower half).
  localparam logic [CFG_DATA_W-1:0] HEADER_WIN_RST       = 32'd655368000;
  localparam logic [CFG_DATA_W-1:0] REPEAT_SPACE_WIN_RST = 32'd176949000;
  localparam logic [CFG_DATA_W-1:0] FULL_SPACE_WIN_RST   = 32'd327684000;
  localparam logic [CFG_DATA_W-1:0] BURST_WIN_RST        = 32'd49152400;
  localparam logic [CFG_DATA_W-1:0] SHORT_SPACE_WIN_RST  = 32'd49152400;
  localparam logic [CFG_DATA_W-1:0] LONG_SPACE_WIN_RST   = 32'd131073400;

  // All six timing windows as one bundle.
  typedef struct packed {
    logic [CFG_DATA_W-1:0] header;
    logic [CFG_DATA_W-1:0] repeat_space;
    logic [CFG_DATA_W-1:0] full_space;
    logic [CFG_DATA_W-1:0] burst;
    logic [CFG_DATA_W-1:0] short_space;
    logic [CFG_DATA_W-1:0] long_space;
  } win_set_t;

  // Which windows hold the current duration.
  typedef struct packed {
    logic header;
    logic repeat_space;
    logic full_space;
    logic burst;
    logic short_space;
    logic long_space;
  } win_hits_t;

endpackage

`default_nettype wire

// ===== hw/rtl/necdec_if.sv =====
// Valid/ready channel interfaces for interval input and decoded frame results.
`timescale 1ns / 1ps
`default_nettype none

interface necdec_in_if
  import necdec_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [DUR_W-1:0] duration_us;
  logic             frame_start;

  modport source (output valid, output duration_us, output frame_start, input ready);
  modport sink   (input valid, input duration_us, input frame_start, output ready);
endinterface

interface necdec_out_if
  import necdec_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CODE_W-1:0]   code_word;
  logic [STATUS_W-1:0] frame_status;

  modport source (output valid, output code_word, output frame_status, input ready);
  modport sink   (input valid, input code_word, input frame_status, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/nec_ir_frame_decoder_top.sv =====
// Top level of the NEC IR frame decoder: config registers, frame tracking, result register.
// Usage:
//   The in_ch channel carries one measured interval per transaction: duration_us
//   (microseconds, saturated at 65535) and frame_start, set on the header mark.
//   The out_ch channel carries at most one result per input transaction:
//   code_word and frame_status (full code, repeat frame or timing failure).
//   Timing windows are written through cfg_we/cfg_index/cfg_wdata while the
//   block is idle; writes take effect at the next clock edge.
// Data path and throughput:
//   An accepted interval is held in the input register, then the window
//   compares and the frame state update run combinationally into the result
//   register, and out_ch.valid rises once that register loads the result for
//   the last interval of a frame. One interval per cycle is accepted while
//   out_ch does not stall.
// Reset and stall:
//   Reset (rst_n low, synchronous) restores the default windows and drops any
//   partial frame. If out_ch stalls, the result register holds; the input
//   register still takes one more interval, then in_ch.ready goes low until
//   the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module nec_ir_frame_decoder_top
  import necdec_pkg::*;
#(
  parameter int unsigned FULL_FRAME_EDGES = FULL_FRAME_EDGES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  necdec_in_if.sink                  in_ch,
  necdec_out_if.source               out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned POS_W = $clog2(FULL_FRAME_EDGES);
  localparam logic [POS_W-1:0] LAST_FULL_POS   = POS_W'(FULL_FRAME_EDGES - 1);
  localparam logic [POS_W-1:0] LAST_REPEAT_POS = POS_W'(REPEAT_FRAME_EDGES - 1);
  localparam logic [POS_W-1:0] POS_ONE         = POS_W'(1);
  localparam logic [POS_W-1:0] POS_TWO         = POS_W'(2);
  localparam logic [POS_W-1:0] POS_THREE       = POS_W'(3);

  win_set_t            win_r;
  logic                s1_valid_r;
  logic [DUR_W-1:0]    s1_dur_r;
  logic                s1_start_r;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                rpt_r, rpt_nxt;
  logic                active_r, active_nxt;
  logic [CODE_W-1:0]   shift_r, shift_nxt;
  logic                out_valid_r;
  logic [CODE_W-1:0]   out_code_r;
  frame_status_t       out_status_r;
  logic                emit;
  logic [CODE_W-1:0]   emit_code;
  frame_status_t       emit_status;
  logic [POS_W-1:0]    bit_idx;
  win_hits_t           hits;
  logic                out_free;
  logic                s1_adv;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r.header       <= HEADER_WIN_RST;
      win_r.repeat_space <= REPEAT_SPACE_WIN_RST;
      win_r.full_space   <= FULL_SPACE_WIN_RST;
      win_r.burst        <= BURST_WIN_RST;
      win_r.short_space  <= SHORT_SPACE_WIN_RST;
      win_r.long_space   <= LONG_SPACE_WIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER_WIN:       win_r.header       <= cfg_wdata;
        CFG_REPEAT_SPACE_WIN: win_r.repeat_space <= cfg_wdata;
        CFG_FULL_SPACE_WIN:   win_r.full_space   <= cfg_wdata;
        CFG_BURST_WIN:        win_r.burst        <= cfg_wdata;
        CFG_SHORT_SPACE_WIN:  win_r.short_space  <= cfg_wdata;
        CFG_LONG_SPACE_WIN:   win_r.long_space   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Handshake: the input register advances whenever the result register can load.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_dur_r   <= in_ch.duration_us;
      s1_start_r <= in_ch.frame_start;
    end
  end

  // Window compares on the registered interval.
  necdec_win_match u_win_match (
    .duration (s1_dur_r),
    .windows  (win_r),
    .hits     (hits)
  );

  // Space at odd position p carries code bit (p - 3) / 2, first bit in bit 31.
  assign bit_idx = (pos_r - POS_THREE) >> 1;

  // Frame tracking step for one interval.
  always_comb begin
    pos_nxt     = pos_r;
    rpt_nxt     = rpt_r;
    active_nxt  = active_r;
    shift_nxt   = shift_r;
    emit        = 1'b0;
    emit_code   = '0;
    emit_status = ST_FAIL;
    if (s1_start_r) begin
      // Header mark: restart the frame.
      shift_nxt = '0;
      rpt_nxt   = 1'b0;
      if (hits.header) begin
        active_nxt = 1'b1;
        pos_nxt    = POS_ONE;
      end else begin
        emit = 1'b1;
      end
    end else if (active_r) begin
      if (pos_r == POS_ONE) begin
        // Header space picks the frame kind; repeat wins on overlap.
        if (hits.repeat_space) begin
          rpt_nxt = 1'b1;
          pos_nxt = POS_TWO;
        end else if (hits.full_space) begin
          rpt_nxt = 1'b0;
          pos_nxt = POS_TWO;
        end else begin
          emit = 1'b1;
        end
      end else if (rpt_r) begin
        if (!hits.burst) begin
          emit = 1'b1;
        end else if (pos_r >= LAST_REPEAT_POS) begin
          emit        = 1'b1;
          emit_code   = REPEAT_CODE;
          emit_status = ST_REPEAT;
        end else begin
          pos_nxt = pos_r + POS_ONE;
        end
      end else if (pos_r >= LAST_FULL_POS) begin
        // Final burst closes a full frame.
        emit = 1'b1;
        if (hits.burst) begin
          emit_code   = shift_r;
          emit_status = ST_FULL;
        end
      end else if (!pos_r[0]) begin
        if (hits.burst) begin
          pos_nxt = pos_r + POS_ONE;
        end else begin
          emit = 1'b1;
        end
      end else begin
        // Bit space: short is zero, long is one.
        if (hits.short_space) begin
          pos_nxt = pos_r + POS_ONE;
        end else if (hits.long_space) begin
          shift_nxt = shift_r | (FIRST_BIT_MASK >> 32'(bit_idx));
          pos_nxt   = pos_r + POS_ONE;
        end else begin
          emit = 1'b1;
        end
      end
    end
    if (emit) begin
      active_nxt = 1'b0;
      pos_nxt    = '0;
    end
  end

  // Frame state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      rpt_r    <= 1'b0;
      active_r <= 1'b0;
      shift_r  <= '0;
    end else if (s1_adv) begin
      pos_r    <= pos_nxt;
      rpt_r    <= rpt_nxt;
      active_r <= active_nxt;
      shift_r  <= shift_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_code_r   <= emit_code;
      out_status_r <= emit_status;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.code_word    = out_code_r;
  assign out_ch.frame_status = out_status_r;

  // A failure result carries a zero code.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FAIL) |-> (out_code_r == '0))
    else $error("failure result with nonzero code");

  // A repeat result carries all ones.
  a_repeat_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_REPEAT) |-> (out_code_r == REPEAT_CODE))
    else $error("repeat result without all-ones code");

  // Any result closes the frame.
  a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && emit) |=> (!active_r && pos_r == '0))
    else $error("frame still active after a result");

  // An idle tracker sits at position zero.
  a_idle_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (pos_r == '0))
    else $error("idle tracker with nonzero position");

  // Position never passes the last interval of a full frame.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_FULL_POS)
    else $error("frame position out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/necdec_win_match.sv =====
// Window compare unit: checks one duration against all six timing windows.
`timescale 1ns / 1ps
`default_nettype none

module necdec_win_match
  import necdec_pkg::*;
(
  input  wire logic [DUR_W-1:0] duration,
  input  wire win_set_t         windows,
  output win_hits_t             hits
);

  // A duration is inside when min (low half) <= d <= max (high half).
  function automatic logic in_win(input logic [CFG_DATA_W-1:0] win,
                                  input logic [DUR_W-1:0] d);
    logic [DUR_W-1:0] lo;
    logic [DUR_W-1:0] hi;
    lo = win[DUR_W-1:0];
    hi = win[CFG_DATA_W-1:DUR_W];
    return (d >= lo) && (d <= hi);
  endfunction

  // Six independent compare pairs.
  always_comb begin
    hits.header       = in_win(windows.header, duration);
    hits.repeat_space = in_win(windows.repeat_space, duration);
    hits.full_space   = in_win(windows.full_space, duration);
    hits.burst        = in_win(windows.burst, duration);
    hits.short_space  = in_win(windows.short_space, duration);
    hits.long_space   = in_win(windows.long_space, duration);
  end

endmodule

`default_nettype wire
